### src/iirbq_pkg.sv
// ----------------------------------------------------------------------------
// iirbq_pkg
// Shared types and constants of the clamped biquad filter: register indexes,
// multiplier operand selection, accumulator operations, controller command.
// ----------------------------------------------------------------------------
`default_nettype none

package iirbq_pkg;

    // default widths of samples and coefficients
    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int DEF_COEF_WIDTH   = 32;

    // configuration register index width and register map
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B0     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B1     = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1     = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2     = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = CFG_INDEX_W'(6);

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_X_B0 = 3'd0,
        MUL_X_B1 = 3'd1,
        MUL_Y_A1 = 3'd2,
        MUL_X_B2 = 3'd3,
        MUL_Y_A2 = 3'd4
    } t_mul_sel;

    // accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD    = 2'd0,
        ACC_TERM    = 2'd1,
        ACC_TERM_W2 = 2'd2,
        ACC_SUB     = 2'd3
    } t_acc_op;

    // controller to datapath commands
    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     calc_y;
        t_acc_op  acc_op;
        logic     load_w1;
        logic     load_w2;
        logic     clear;
        logic     load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_req;
    } t_dp_status;

endpackage : iirbq_pkg

`default_nettype wire

### src/iirbq_if.sv
// ----------------------------------------------------------------------------
// iirbq_if
// Channel interfaces of the biquad filter: input samples, output results and
// configuration writes, each with a valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirbq_in_if #(
    parameter int SAMPLE_WIDTH = iirbq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_state;

    modport source (output valid, output sample_in, output clear_state, input ready);
    modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface : iirbq_in_if

interface iirbq_out_if #(
    parameter int SAMPLE_WIDTH = iirbq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink   (input valid, input filtered_out, output ready);
endinterface : iirbq_out_if

interface iirbq_cfg_if #(
    parameter int DATA_WIDTH = iirbq_pkg::DEF_SAMPLE_WIDTH
);
    logic                               valid;
    logic                               ready;
    logic [iirbq_pkg::CFG_INDEX_W-1:0]  index;
    logic [DATA_WIDTH-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : iirbq_cfg_if

`default_nettype wire

### src/iirbq_ctrl.sv
// ----------------------------------------------------------------------------
// iirbq_ctrl
// Sequencer of the biquad filter: steps one sample through the shared
// multiplier schedule and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module iirbq_ctrl
    import iirbq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MB0  = 8'b0000_0010,
        ST_YC   = 8'b0000_0100,
        ST_A1   = 8'b0000_1000,
        ST_B2   = 8'b0001_0000,
        ST_A2   = 8'b0010_0000,
        ST_W2   = 8'b0100_0000,
        ST_CLR  = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // decode state into datapath commands and next state
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_X_B0;
        cmd.acc_op  = ACC_HOLD;
        n_state     = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_x = 1'b1;
                    n_state    = ST_MB0;
                end
            end
            ST_MB0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X_B0;
                n_state     = i_status.clear_req ? ST_CLR : ST_YC;
            end
            ST_YC: begin
                cmd.calc_y  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X_B1;
                n_state     = ST_A1;
            end
            ST_A1: begin
                cmd.acc_op  = ACC_TERM_W2;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y_A1;
                n_state     = ST_B2;
            end
            ST_B2: begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X_B2;
                n_state     = ST_A2;
            end
            ST_A2: begin
                cmd.load_w1 = 1'b1;
                cmd.acc_op  = ACC_TERM;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y_A2;
                n_state     = ST_W2;
            end
            ST_W2: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.load_w2  = 1'b1;
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (out_free) begin
                    cmd.clear    = 1'b1;
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd = cmd;

    // output valid: set on load, drop on transfer
    always_comb begin
        priority if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // an accepted sample starts the multiply sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MB0))
        else $error("accepted sample did not start the sequence");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a finished result leaves the sequencer idle with a valid output
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> (r_state == ST_IDLE && r_out_valid))
        else $error("sequence did not end after loading the result");

endmodule : iirbq_ctrl

`default_nettype wire

### src/iirbq_dp.sv
// ----------------------------------------------------------------------------
// iirbq_dp
// Datapath of the biquad filter: configuration registers, one shared
// multiplier, accumulator, output clamp and saturating delay registers.
// ----------------------------------------------------------------------------
`default_nettype none

module iirbq_dp
    import iirbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int CFG_WIDTH    = DEF_SAMPLE_WIDTH
)(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_dp_cmd                        i_cmd,
    output t_dp_status                          o_status,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic                           i_clear_state,
    input  wire logic                           i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]           i_cfg_data,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_out
);

    localparam int STW = SAMPLE_WIDTH + 8;          // state width
    localparam int CF  = COEF_WIDTH - 8;            // coefficient fraction bits
    localparam int PW  = SAMPLE_WIDTH + COEF_WIDTH; // product width
    localparam int AW  = STW + 2;                   // accumulator width

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SAMPLE_WIDTH-1:0] r_upper, r_lower;

    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y, r_out;
    logic                           r_clr;
    logic signed [PW-1:0]           r_prod, n_prod;
    logic signed [AW-1:0]           r_acc, n_acc;
    logic signed [STW-1:0]          r_w1, r_w2;

    logic signed [SAMPLE_WIDTH-1:0] op_s;
    logic signed [COEF_WIDTH-1:0]   op_c;
    logic signed [STW-1:0]          term;
    logic signed [STW:0]            sum_y, upper_ext, lower_ext;
    logic signed [SAMPLE_WIDTH-1:0] n_y;
    logic signed [AW-1:0]           w2_sum;

    // clip an accumulator value to the state range
    function automatic logic signed [STW-1:0] sat_state(input logic signed [AW-1:0] v);
        logic [AW-STW:0] top;
        top = v[AW-1:STW-1];
        if ((&top) || !(|top)) begin
            return v[STW-1:0];
        end else if (v[AW-1]) begin
            return {1'b1, {(STW-1){1'b0}}};
        end else begin
            return {1'b0, {(STW-1){1'b1}}};
        end
    endfunction

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= '0;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_upper <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            r_lower <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COEF_B0:     r_b0    <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_B1:     r_b1    <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_B2:     r_b2    <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_A1:     r_a1    <= i_cfg_data[COEF_WIDTH-1:0];
                REG_COEF_A2:     r_a2    <= i_cfg_data[COEF_WIDTH-1:0];
                REG_UPPER_LIMIT: r_upper <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_LOWER_LIMIT: r_lower <= i_cfg_data[SAMPLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_X_B0: begin op_s = r_x; op_c = r_b0; end
            MUL_X_B1: begin op_s = r_x; op_c = r_b1; end
            MUL_Y_A1: begin op_s = r_y; op_c = r_a1; end
            MUL_X_B2: begin op_s = r_x; op_c = r_b2; end
            MUL_Y_A2: begin op_s = r_y; op_c = r_a2; end
            default:  begin op_s = r_x; op_c = r_b0; end
        endcase
    end

    assign n_prod = PW'(op_s) * PW'(op_c);

    // drop fraction bits: floor rounding by bit select
    assign term = r_prod[PW-1:CF];

    // clamp b0*x + w1, upper bound first
    assign sum_y     = {term[STW-1], term} + {r_w1[STW-1], r_w1};
    assign upper_ext = {{(STW+1-SAMPLE_WIDTH){r_upper[SAMPLE_WIDTH-1]}}, r_upper};
    assign lower_ext = {{(STW+1-SAMPLE_WIDTH){r_lower[SAMPLE_WIDTH-1]}}, r_lower};

    always_comb begin
        priority if (sum_y > upper_ext) begin
            n_y = r_upper;
        end else if (sum_y < lower_ext) begin
            n_y = r_lower;
        end else begin
            n_y = sum_y[SAMPLE_WIDTH-1:0];
        end
    end

    // accumulator operations
    always_comb begin
        unique case (i_cmd.acc_op)
            ACC_TERM:    n_acc = AW'(term);
            ACC_TERM_W2: n_acc = AW'(term) + AW'(r_w2);
            ACC_SUB:     n_acc = r_acc - AW'(term);
            default:     n_acc = r_acc;
        endcase
    end

    assign w2_sum = r_acc - AW'(term);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x   <= i_sample_in;
            r_clr <= i_clear_state;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.calc_y) begin
            r_y <= n_y;
        end
        r_acc <= n_acc;
        if (i_cmd.load_out) begin
            r_out <= i_cmd.clear ? '0 : r_y;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_cmd.clear) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else begin
            if (i_cmd.load_w1) begin
                r_w1 <= sat_state(r_acc);
            end
            if (i_cmd.load_w2) begin
                r_w2 <= sat_state(w2_sum);
            end
        end
    end

    assign o_status.clear_req = r_clr;
    assign o_filtered_out     = r_out;

endmodule : iirbq_dp

`default_nettype wire

### src/iir_biquad_tdf2_clamped_unit.sv
// ----------------------------------------------------------------------------
// iir_biquad_tdf2_clamped_unit
// Clamped second-order IIR filter, transposed direct form II, fixed point.
//
// Channels: i_in carries a Q16.16 sample and a clear flag, o_out carries the
// clamped Q16.16 result, i_cfg writes the coefficient and limit registers
// (index 0..6: b0, b1, b2, a1, a2, upper limit, lower limit; others are
// ignored). The configuration channel is always ready; write it while idle.
// Each sample gives exactly one result. A sample passes the accept cycle,
// then the five products, which go one per cycle through a single shared
// multiplier, then the state write-back, which also loads the result. A
// clear request stops after the first product: it zeroes the state and
// gives a zero result, and then the sequencer returns to idle.
// The result sits in an output register, so the next sample is taken while
// it waits; if the receiver stalls, the next result holds in the sequencer
// until the register frees, and input stalls behind it.
// Reset zeroes the delay registers, sets coefficients to zero and the limits
// to the full sample range; reset takes effect at once, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_biquad_tdf2_clamped_unit
    import iirbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
)(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    iirbq_in_if.sink     i_in,
    iirbq_out_if.source  o_out,
    iirbq_cfg_if.sink    i_cfg
);

    localparam int CFG_WIDTH = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_we;

    // configuration writes are always accepted and registered
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    iirbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    iirbq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .CFG_WIDTH    (CFG_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample_in    (i_in.sample_in),
        .i_clear_state  (i_in.clear_state),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data[CFG_WIDTH-1:0]),
        .o_filtered_out (o_out.filtered_out)
    );

endmodule : iir_biquad_tdf2_clamped_unit

`default_nettype wire
